// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Property checked at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Antecedent in one cycle implies consequent in the next.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- rtl/itms_pkg.sv -----
// Shared types, constants and helpers of the inverse transform matrix stage.
package itms_pkg;

    localparam int MAX_SIZE_DEF  = 32;
    localparam int ACC_WIDTH_DEF = 32;
    localparam int PROD_W        = 32;
    localparam int CFG_DATA_W    = 5;
    localparam int CFG_IDX_W     = 1;
    localparam int N_W           = 7;   // holds a line size up to 64

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_DATA  = 1'b1
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SIZE_LOG2   = 1'b0,
        REG_ROUND_SHIFT = 1'b1
    } t_reg_idx;

    // Settings seen by every pipeline part.
    typedef struct packed {
        logic           adv;    // pipeline moves this cycle
        logic [N_W-1:0] n;      // current line size
        logic [4:0]     shift;  // rounding shift
    } t_pipe_ctrl;

    // Data beat entering the multiply stage.
    typedef struct packed {
        logic               valid;
        logic               hit;    // row inside the current size
        logic               last;
        logic signed [15:0] value;
    } t_mac_item;

    function automatic logic [N_W-1:0] line_size(logic [2:0] size_log2, int max_size);
        logic [2:0]     l;
        logic [N_W-1:0] n;
        l = size_log2;
        if (l < 3'd2) l = 3'd2;
        if (l > 3'd5) l = 3'd5;
        n = N_W'(1) << l;
        if (int'(n) > max_size) n = N_W'(max_size);
        return n;
    endfunction

endpackage

// ----- rtl/itms_in_if.sv -----
// Input channel: matrix writes and data coefficients.
interface itms_in_if;
    logic               valid;
    logic               ready;
    logic               command;
    logic [4:0]         row_index;
    logic [4:0]         col_index;
    logic signed [15:0] value;
    logic               last_row;

    modport source (output valid, command, row_index, col_index, value, last_row,
                    input ready);
    modport sink   (input valid, command, row_index, col_index, value, last_row,
                    output ready);
endinterface

// ----- rtl/itms_out_if.sv -----
// Output channel: rounded and saturated samples.
interface itms_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;
    logic [4:0]         out_index;
    logic               last_of_run;

    modport source (output valid, sample, out_index, last_of_run, input ready);
    modport sink   (input valid, sample, out_index, last_of_run, output ready);
endinterface

// ----- rtl/itms_coef_mem.sv -----
// Transform matrix store: entry-wide write port, row-wide registered read port.
module itms_coef_mem #(
    parameter int MAX_SIZE = itms_pkg::MAX_SIZE_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [$clog2(MAX_SIZE)-1:0] i_wrow,
    input  logic [$clog2(MAX_SIZE)-1:0] i_wcol,
    input  logic signed [15:0]          i_wdata,
    input  logic                        i_re,
    input  logic [$clog2(MAX_SIZE)-1:0] i_rrow,
    output logic signed [15:0]          o_rdata [MAX_SIZE]
);

    logic signed [15:0] r_mem [MAX_SIZE][MAX_SIZE];
    logic signed [15:0] r_rd  [MAX_SIZE];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wrow][i_wcol] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rd <= r_mem[i_rrow];
        end
    end

    assign o_rdata = r_rd;

endmodule

// ----- rtl/itms_mac.sv -----
// Row multipliers and column accumulators.
module itms_mac #(
    parameter int MAX_SIZE  = itms_pkg::MAX_SIZE_DEF,
    parameter int ACC_WIDTH = itms_pkg::ACC_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  itms_pkg::t_pipe_ctrl        i_ctrl,
    input  itms_pkg::t_mac_item         i_item,
    input  logic signed [15:0]          i_row [MAX_SIZE],
    output logic                        o_cap,
    output logic                        o_last_pend,
    output logic signed [ACC_WIDTH-1:0] o_sum [MAX_SIZE]
);

    itms_pkg::t_mac_item                 r_s1;
    logic                                r_s2_v;
    logic                                r_s2_last;
    logic signed [itms_pkg::PROD_W-1:0]  r_prod [MAX_SIZE];
    logic signed [itms_pkg::PROD_W-1:0]  n_prod [MAX_SIZE];
    logic signed [ACC_WIDTH-1:0]         r_acc  [MAX_SIZE];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1      <= '0;
            r_s2_v    <= 1'b0;
            r_s2_last <= 1'b0;
        end else if (i_ctrl.adv) begin
            r_s1      <= i_item;
            r_s2_v    <= r_s1.valid;
            r_s2_last <= r_s1.last;
        end
    end

    // columns beyond the line size and rows outside it add nothing
    always_comb begin
        for (int c = 0; c < MAX_SIZE; c++) begin
            if (r_s1.valid && r_s1.hit && c < int'(i_ctrl.n)) begin
                n_prod[c] = itms_pkg::PROD_W'(r_s1.value) * itms_pkg::PROD_W'(i_row[c]);
            end else begin
                n_prod[c] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.adv) begin
            r_prod <= n_prod;
        end
    end

    always_comb begin
        for (int c = 0; c < MAX_SIZE; c++) begin
            o_sum[c] = r_acc[c] + ACC_WIDTH'(r_prod[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < MAX_SIZE; c++) r_acc[c] <= '0;
        end else if (i_ctrl.adv && r_s2_v) begin
            for (int c = 0; c < MAX_SIZE; c++) begin
                r_acc[c] <= r_s2_last ? '0 : o_sum[c];
            end
        end
    end

    assign o_last_pend = r_s2_v && r_s2_last;
    assign o_cap       = i_ctrl.adv && o_last_pend;

endmodule

// ----- rtl/itms_drain.sv -----
// Snapshot bank of finished sums and the round, shift, saturate output path.
module itms_drain #(
    parameter int MAX_SIZE  = itms_pkg::MAX_SIZE_DEF,
    parameter int ACC_WIDTH = itms_pkg::ACC_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  itms_pkg::t_pipe_ctrl        i_ctrl,
    input  logic                        i_cap,
    input  logic signed [ACC_WIDTH-1:0] i_sum [MAX_SIZE],
    output logic                        o_busy,
    output logic                        o_done,
    itms_out_if.source                  o_out
);

    localparam int CNT_W = $clog2(MAX_SIZE);
    localparam logic signed [ACC_WIDTH-1:0] SAT_HI = ACC_WIDTH'(32767);
    localparam logic signed [ACC_WIDTH-1:0] SAT_LO = ACC_WIDTH'(-32768);

    logic signed [ACC_WIDTH-1:0]   r_snap [MAX_SIZE];
    logic                          r_busy;
    logic [CNT_W-1:0]              r_cnt;
    logic [itms_pkg::N_W-1:0]      r_n;
    logic                          r_pre_v;
    logic signed [ACC_WIDTH-1:0]   r_pre_sum;
    logic [4:0]                    r_pre_idx;
    logic                          r_pre_last;
    logic                          r_out_v;
    logic signed [15:0]            r_out_sample;
    logic [4:0]                    r_out_idx;
    logic                          r_out_last;

    logic                          w_out_en;
    logic                          w_pre_en;
    logic                          w_step;
    logic                          w_cnt_last;
    logic [ACC_WIDTH-1:0]          w_rnd;
    logic signed [ACC_WIDTH-1:0]   w_shr;
    logic signed [15:0]            w_sample;

    assign w_out_en   = !r_out_v || o_out.ready;
    assign w_pre_en   = !r_pre_v || w_out_en;
    assign w_step     = r_busy && w_pre_en;
    assign w_cnt_last = (itms_pkg::N_W'(r_cnt) == r_n - itms_pkg::N_W'(1));

    // half-LSB rounding term, none for a zero shift
    assign w_rnd = (i_ctrl.shift == 5'd0) ? '0 : (ACC_WIDTH'(1) << (i_ctrl.shift - 5'd1));

    assign w_shr    = r_pre_sum >>> i_ctrl.shift;
    assign w_sample = (w_shr > SAT_HI) ? 16'sh7fff :
                      (w_shr < SAT_LO) ? 16'sh8000 : w_shr[15:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_cnt   <= '0;
            r_pre_v <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (i_cap) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (w_step) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (w_cnt_last) begin
                    r_busy <= 1'b0;
                end
            end
            if (w_pre_en) begin
                r_pre_v <= w_step;
            end
            if (w_out_en) begin
                r_out_v <= r_pre_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cap) begin
            r_snap <= i_sum;
            r_n    <= i_ctrl.n;
        end
        if (w_step) begin
            r_pre_sum  <= r_snap[r_cnt] + w_rnd;
            r_pre_idx  <= 5'(r_cnt);
            r_pre_last <= w_cnt_last;
        end
        if (w_out_en) begin
            r_out_sample <= w_sample;
            r_out_idx    <= r_pre_idx;
            r_out_last   <= r_pre_last;
        end
    end

    assign o_busy            = r_busy;
    // last entry of the bank is read out this cycle; a new line may land now
    assign o_done            = w_step && w_cnt_last;
    assign o_out.valid       = r_out_v;
    assign o_out.sample      = r_out_sample;
    assign o_out.out_index   = r_out_idx;
    assign o_out.last_of_run = r_out_last;

endmodule

// ----- rtl/inverse_transform_matrix_stage_unit.sv -----
// Top level of the one-dimensional inverse transform matrix stage.

// Streamed vector-matrix inverse transform for 4, 8, 16 and 32 points. Matrix
// write beats (command 0) store one signed entry; data beats (command 1) bring
// one coefficient and its row, which is multiplied by the whole stored row in
// MAX_SIZE parallel multipliers and summed into the column accumulators. The
// input takes one beat per cycle. A beat with last_row set hands the line's
// sums to a snapshot bank and clears the accumulators; the bank then emits N
// results, one per cycle while the output is ready, each rounded by 2^(shift-1),
// shifted right arithmetically and saturated to 16 bits. When the bank is free,
// a line's first result passes the input, product, snapshot, rounding and output
// registers after its last data beat is accepted. The input stalls only when a
// last beat reaches the accumulate stage while the bank is busy and not reading
// out its final sum, so a line of at least N beats sustains one beat per cycle
// while the output is ready; shorter lines are limited by the single output port.
// Matrix entries read before being written are undefined.
// Registers: index 0 size_log2 (clamped to 2..5), index 1 round_shift; write
// them only while no line is in flight.
`include "assert_macros.svh"

module inverse_transform_matrix_stage_unit #(
    parameter int MAX_SIZE  = itms_pkg::MAX_SIZE_DEF,
    parameter int ACC_WIDTH = itms_pkg::ACC_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [itms_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [itms_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    itms_in_if.sink                             i_in,
    itms_out_if.source                          o_out
);

    localparam int ROW_W = $clog2(MAX_SIZE);

    // configuration
    logic [2:0]                r_size_log2;
    logic [4:0]                r_round_shift;

    itms_pkg::t_pipe_ctrl      w_ctrl;
    itms_pkg::t_mac_item       w_item;
    logic                      w_adv;
    logic                      w_accept;
    logic                      w_wr;
    logic [6:0]                w_row_x;
    logic [6:0]                w_col_x;
    logic signed [15:0]        w_row_data [MAX_SIZE];
    logic signed [ACC_WIDTH-1:0] w_sum   [MAX_SIZE];
    logic                      mac_cap;
    logic                      mac_last_pend;
    logic                      drain_busy;
    logic                      drain_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_log2   <= 3'd5;
            r_round_shift <= 5'd7;
        end else if (i_cfg_we) begin
            case (itms_pkg::t_reg_idx'(i_cfg_idx))
                itms_pkg::REG_SIZE_LOG2:   r_size_log2   <= i_cfg_data[2:0];
                itms_pkg::REG_ROUND_SHIFT: r_round_shift <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input and MAC stages hold only when a finished line waits for the bank;
    // the bank takes a new line in the cycle its last entry is read out.
    assign w_adv    = !(mac_last_pend && drain_busy && !drain_done);
    assign i_in.ready = w_adv;
    assign w_accept = i_in.valid && w_adv;

    assign w_ctrl.adv   = w_adv;
    assign w_ctrl.n     = itms_pkg::line_size(r_size_log2, MAX_SIZE);
    assign w_ctrl.shift = r_round_shift;

    assign w_row_x = 7'(i_in.row_index);
    assign w_col_x = 7'(i_in.col_index);

    // matrix writes outside the store are dropped
    assign w_wr = w_accept && (i_in.command == itms_pkg::CMD_WRITE)
                  && (int'(w_row_x) < MAX_SIZE) && (int'(w_col_x) < MAX_SIZE);

    // data beats enter the multiply stage together with their matrix row
    assign w_item.valid = w_accept && (i_in.command == itms_pkg::CMD_DATA);
    assign w_item.hit   = w_row_x < w_ctrl.n;
    assign w_item.last  = i_in.last_row;
    assign w_item.value = i_in.value;

    itms_coef_mem #(
        .MAX_SIZE (MAX_SIZE)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_wr),
        .i_wrow  (w_row_x[ROW_W-1:0]),
        .i_wcol  (w_col_x[ROW_W-1:0]),
        .i_wdata (i_in.value),
        .i_re    (w_adv),
        .i_rrow  (w_row_x[ROW_W-1:0]),
        .o_rdata (w_row_data)
    );

    itms_mac #(
        .MAX_SIZE  (MAX_SIZE),
        .ACC_WIDTH (ACC_WIDTH)
    ) u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_ctrl),
        .i_item      (w_item),
        .i_row       (w_row_data),
        .o_cap       (mac_cap),
        .o_last_pend (mac_last_pend),
        .o_sum       (w_sum)
    );

    itms_drain #(
        .MAX_SIZE  (MAX_SIZE),
        .ACC_WIDTH (ACC_WIDTH)
    ) u_drain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .i_cap   (mac_cap),
        .i_sum   (w_sum),
        .o_busy  (drain_busy),
        .o_done  (drain_done),
        .o_out   (o_out)
    );

    // input stalls only behind a draining line
    `ASSERT_CLK(a_stall_needs_busy, i_clk, i_rst_n, !i_in.ready |-> drain_busy, "stall without drain")
    // a captured line always starts a drain
    `ASSERT_NEXT(a_cap_starts_drain, i_clk, i_rst_n, mac_cap, drain_busy, "capture lost")
    // drain starts only from a capture
    `ASSERT_CLK(a_busy_from_cap, i_clk, i_rst_n, $rose(drain_busy) |-> $past(mac_cap), "drain w/o capture")

endmodule
